// ===== src/bpbf_pkg.sv =====
package bpbf_pkg;

  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned ID_W        = 32;
  localparam int unsigned SLOT_OUT_W  = 4;
  localparam int unsigned LCNT_OUT_W  = 5;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned REQ_W       = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOCK   = 2'd0,
    OP_UNLOCK = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_REUSED   = 3'd0,
    STS_GROWN    = 3'd1,
    STS_NEW      = 3'd2,
    STS_FULL     = 3'd3,
    STS_UNLOCKED = 3'd4,
    STS_NOTFOUND = 3'd5,
    STS_CLEARED  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    CM_NONE,
    CM_LOCK,
    CM_GROW,
    CM_NEW,
    CM_UNLOCK,
    CM_CLEAR
  } commit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    op_t  op;
    logic fit_ok;
    logic grow_ok;
    logic found;
  } scan_flags_t;

endpackage

// ===== src/bpbf_in_if.sv =====
interface bpbf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] request_size;
  logic [31:0] release_id;

  modport source (output valid, output operation, output request_size, output release_id,
                  input ready);
  modport sink (input valid, input operation, input request_size, input release_id,
                output ready);
endinterface

// ===== src/bpbf_out_if.sv =====
interface bpbf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] granted_id;
  logic [3:0]  granted_slot;
  logic [4:0]  still_locked_count;

  modport source (output valid, output status, output granted_id, output granted_slot,
                  output still_locked_count, input ready);
  modport sink (input valid, input status, input granted_id, input granted_slot,
                input still_locked_count, output ready);
endinterface

// ===== src/bpbf_cell.sv =====
module bpbf_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned SIZE_BITS = 32,
  parameter int unsigned SLOT_W    = 4,
  parameter int unsigned CNT_W     = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_use_i,
  // scan token from the previous cell
  input  logic                      scan_v_i,
  input  bpbf_pkg::scan_flags_t     flags_i,
  input  logic [SIZE_BITS-1:0]      req_i,
  input  logic [bpbf_pkg::ID_W-1:0] rid_i,
  input  logic [SIZE_BITS-1:0]      fit_size_i,
  input  logic [SLOT_W-1:0]         fit_slot_i,
  input  logic [bpbf_pkg::ID_W-1:0] fit_id_i,
  input  logic [SIZE_BITS-1:0]      grow_size_i,
  input  logic [SLOT_W-1:0]         grow_slot_i,
  input  logic [bpbf_pkg::ID_W-1:0] grow_id_i,
  input  logic [SLOT_W-1:0]         found_slot_i,
  input  logic [CNT_W-1:0]          lcnt_i,
  // scan token to the next cell
  output logic                      scan_v_o,
  output bpbf_pkg::scan_flags_t     flags_o,
  output logic [SIZE_BITS-1:0]      req_o,
  output logic [bpbf_pkg::ID_W-1:0] rid_o,
  output logic [SIZE_BITS-1:0]      fit_size_o,
  output logic [SLOT_W-1:0]         fit_slot_o,
  output logic [bpbf_pkg::ID_W-1:0] fit_id_o,
  output logic [SIZE_BITS-1:0]      grow_size_o,
  output logic [SLOT_W-1:0]         grow_slot_o,
  output logic [bpbf_pkg::ID_W-1:0] grow_id_o,
  output logic [SLOT_W-1:0]         found_slot_o,
  output logic [CNT_W-1:0]          lcnt_o,
  // update broadcast
  input  bpbf_pkg::commit_t         cm_kind_i,
  input  logic [SLOT_W-1:0]         cm_slot_i,
  input  logic [SIZE_BITS-1:0]      cm_size_i,
  input  logic [bpbf_pkg::ID_W-1:0] cm_id_i
);

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

  logic [SIZE_BITS-1:0]      size_r;
  logic [bpbf_pkg::ID_W-1:0] id_r;
  logic                      locked_r;

  logic                      scan_v_r;
  bpbf_pkg::scan_flags_t     flags_r;
  logic [SIZE_BITS-1:0]      req_r;
  logic [bpbf_pkg::ID_W-1:0] rid_r;
  logic [SIZE_BITS-1:0]      fit_size_r;
  logic [SLOT_W-1:0]         fit_slot_r;
  logic [bpbf_pkg::ID_W-1:0] fit_id_r;
  logic [SIZE_BITS-1:0]      grow_size_r;
  logic [SLOT_W-1:0]         grow_slot_r;
  logic [bpbf_pkg::ID_W-1:0] grow_id_r;
  logic [SLOT_W-1:0]         found_slot_r;
  logic [CNT_W-1:0]          lcnt_r;

  logic free_entry;
  logic fit_hit;
  logic grow_hit;
  logic id_hit;
  logic slot_match;

  assign free_entry = in_use_i && !locked_r;
  assign fit_hit    = free_entry && (size_r >= req_i) &&
                      (!flags_i.fit_ok || (size_r < fit_size_i));
  assign grow_hit   = free_entry && (size_r != '0) && (size_r < req_i) &&
                      (!flags_i.grow_ok || (size_r > grow_size_i));
  assign id_hit     = in_use_i && !flags_i.found && (id_r == rid_i);
  assign slot_match = (cm_slot_i == MY_SLOT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_v_r <= 1'b0;
    end else begin
      scan_v_r <= scan_v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_v_i) begin
      flags_r.op      <= flags_i.op;
      flags_r.fit_ok  <= flags_i.fit_ok || fit_hit;
      flags_r.grow_ok <= flags_i.grow_ok || grow_hit;
      flags_r.found   <= flags_i.found || id_hit;
      req_r           <= req_i;
      rid_r           <= rid_i;
      fit_size_r      <= fit_hit ? size_r : fit_size_i;
      fit_slot_r      <= fit_hit ? MY_SLOT : fit_slot_i;
      fit_id_r        <= fit_hit ? id_r : fit_id_i;
      grow_size_r     <= grow_hit ? size_r : grow_size_i;
      grow_slot_r     <= grow_hit ? MY_SLOT : grow_slot_i;
      grow_id_r       <= grow_hit ? id_r : grow_id_i;
      found_slot_r    <= id_hit ? MY_SLOT : found_slot_i;
      lcnt_r          <= lcnt_i + CNT_W'(in_use_i && locked_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r <= 1'b0;
    end else begin
      unique case (cm_kind_i)
        bpbf_pkg::CM_LOCK: begin
          if (slot_match) locked_r <= 1'b1;
        end
        bpbf_pkg::CM_GROW: begin
          if (slot_match) locked_r <= 1'b1;
        end
        bpbf_pkg::CM_NEW: begin
          if (slot_match) locked_r <= 1'b1;
        end
        bpbf_pkg::CM_UNLOCK: begin
          if (slot_match) locked_r <= 1'b0;
        end
        bpbf_pkg::CM_CLEAR: begin
          locked_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (slot_match && ((cm_kind_i == bpbf_pkg::CM_GROW) || (cm_kind_i == bpbf_pkg::CM_NEW))) begin
      size_r <= cm_size_i;
    end
    if (slot_match && (cm_kind_i == bpbf_pkg::CM_NEW)) begin
      id_r <= cm_id_i;
    end
  end

  assign scan_v_o     = scan_v_r;
  assign flags_o      = flags_r;
  assign req_o        = req_r;
  assign rid_o        = rid_r;
  assign fit_size_o   = fit_size_r;
  assign fit_slot_o   = fit_slot_r;
  assign fit_id_o     = fit_id_r;
  assign grow_size_o  = grow_size_r;
  assign grow_slot_o  = grow_slot_r;
  assign grow_id_o    = grow_id_r;
  assign found_slot_o = found_slot_r;
  assign lcnt_o       = lcnt_r;

endmodule

// ===== src/buffer_pool_best_fit_lock.sv =====
// channel  dir  signals                                                   handshake
// in_ch    in   operation, request_size, release_id                       valid/ready
// out_ch   out  status, granted_id, granted_slot, still_locked_count     valid/ready
//
// one item at a time: it walks the row of TABLE_ENTRIES cells, one cell a cycle
// the result register loads when the scan leaves the last cell and the output is free
// input ready returns on the edge that loads the result register
// the table update is applied on the edge that loads the result register
// rst_n is synchronous; it empties the table and zeroes the id counter
// a stalled result holds the last scan in the final cell; input stays blocked
module buffer_pool_best_fit_lock #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned SIZE_BITS     = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  bpbf_in_if.sink    in_ch,
  bpbf_out_if.source out_ch
);

  localparam int unsigned SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ID_W   = bpbf_pkg::ID_W;

  logic [TABLE_ENTRIES:0]  scan_v;
  bpbf_pkg::scan_flags_t   c_flags      [0:TABLE_ENTRIES];
  logic [SIZE_BITS-1:0]    c_req        [0:TABLE_ENTRIES];
  logic [ID_W-1:0]         c_rid        [0:TABLE_ENTRIES];
  logic [SIZE_BITS-1:0]    c_fit_size   [0:TABLE_ENTRIES];
  logic [SLOT_W-1:0]       c_fit_slot   [0:TABLE_ENTRIES];
  logic [ID_W-1:0]         c_fit_id     [0:TABLE_ENTRIES];
  logic [SIZE_BITS-1:0]    c_grow_size  [0:TABLE_ENTRIES];
  logic [SLOT_W-1:0]       c_grow_slot  [0:TABLE_ENTRIES];
  logic [ID_W-1:0]         c_grow_id    [0:TABLE_ENTRIES];
  logic [SLOT_W-1:0]       c_found_slot [0:TABLE_ENTRIES];
  logic [CNT_W-1:0]        c_lcnt       [0:TABLE_ENTRIES];

  bpbf_pkg::state_t        state_r;
  bpbf_pkg::state_t        state_nxt;
  logic [CNT_W-1:0]        count_r;
  logic [ID_W-1:0]         id_ctr_r;

  logic                    accept;
  logic                    fire;
  logic                    out_free;
  bpbf_pkg::commit_t       dec_kind;
  bpbf_pkg::commit_t       cm_kind;
  logic [SLOT_W-1:0]       cm_slot;
  logic [ID_W-1:0]         new_id;
  bpbf_pkg::status_t       dec_status;
  logic [ID_W-1:0]         dec_id;
  logic [SLOT_W-1:0]       dec_slot;
  logic [CNT_W-1:0]        dec_lcnt;

  logic                    out_valid_r;
  bpbf_pkg::status_t       status_r;
  logic [ID_W-1:0]         gid_r;
  logic [SLOT_W-1:0]       gslot_r;
  logic [CNT_W-1:0]        lcnt_r;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // head of the row
  assign scan_v[0]         = accept;
  assign c_flags[0].op     = bpbf_pkg::op_t'(in_ch.operation);
  assign c_flags[0].fit_ok  = 1'b0;
  assign c_flags[0].grow_ok = 1'b0;
  assign c_flags[0].found   = 1'b0;
  assign c_req[0]          = SIZE_BITS'(in_ch.request_size);
  assign c_rid[0]          = in_ch.release_id;
  assign c_fit_size[0]     = '0;
  assign c_fit_slot[0]     = '0;
  assign c_fit_id[0]       = '0;
  assign c_grow_size[0]    = '0;
  assign c_grow_slot[0]    = '0;
  assign c_grow_id[0]      = '0;
  assign c_found_slot[0]   = '0;
  assign c_lcnt[0]         = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    bpbf_cell #(
      .IDX       (i),
      .SIZE_BITS (SIZE_BITS),
      .SLOT_W    (SLOT_W),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .in_use_i     (CNT_W'(i) < count_r),
      .scan_v_i     (scan_v[i]),
      .flags_i      (c_flags[i]),
      .req_i        (c_req[i]),
      .rid_i        (c_rid[i]),
      .fit_size_i   (c_fit_size[i]),
      .fit_slot_i   (c_fit_slot[i]),
      .fit_id_i     (c_fit_id[i]),
      .grow_size_i  (c_grow_size[i]),
      .grow_slot_i  (c_grow_slot[i]),
      .grow_id_i    (c_grow_id[i]),
      .found_slot_i (c_found_slot[i]),
      .lcnt_i       (c_lcnt[i]),
      .scan_v_o     (scan_v[i+1]),
      .flags_o      (c_flags[i+1]),
      .req_o        (c_req[i+1]),
      .rid_o        (c_rid[i+1]),
      .fit_size_o   (c_fit_size[i+1]),
      .fit_slot_o   (c_fit_slot[i+1]),
      .fit_id_o     (c_fit_id[i+1]),
      .grow_size_o  (c_grow_size[i+1]),
      .grow_slot_o  (c_grow_slot[i+1]),
      .grow_id_o    (c_grow_id[i+1]),
      .found_slot_o (c_found_slot[i+1]),
      .lcnt_o       (c_lcnt[i+1]),
      .cm_kind_i    (cm_kind),
      .cm_slot_i    (cm_slot),
      .cm_size_i    (c_req[TABLE_ENTRIES]),
      .cm_id_i      (new_id)
    );
  end

  assign new_id = id_ctr_r + ID_W'(1);

  // decision at the tail of the row
  always_comb begin
    dec_kind   = bpbf_pkg::CM_NONE;
    dec_status = bpbf_pkg::STS_NOTFOUND;
    dec_id     = '0;
    dec_slot   = '0;
    dec_lcnt   = '0;
    unique case (c_flags[TABLE_ENTRIES].op)
      bpbf_pkg::OP_LOCK: begin
        priority if (c_flags[TABLE_ENTRIES].fit_ok) begin
          dec_kind   = bpbf_pkg::CM_LOCK;
          dec_status = bpbf_pkg::STS_REUSED;
          dec_id     = c_fit_id[TABLE_ENTRIES];
          dec_slot   = c_fit_slot[TABLE_ENTRIES];
        end else if (c_flags[TABLE_ENTRIES].grow_ok) begin
          dec_kind   = bpbf_pkg::CM_GROW;
          dec_status = bpbf_pkg::STS_GROWN;
          dec_id     = c_grow_id[TABLE_ENTRIES];
          dec_slot   = c_grow_slot[TABLE_ENTRIES];
        end else if (count_r < CNT_W'(TABLE_ENTRIES)) begin
          dec_kind   = bpbf_pkg::CM_NEW;
          dec_status = bpbf_pkg::STS_NEW;
          dec_id     = new_id;
          dec_slot   = count_r[SLOT_W-1:0];
        end else begin
          dec_status = bpbf_pkg::STS_FULL;
        end
      end
      bpbf_pkg::OP_UNLOCK: begin
        if (c_flags[TABLE_ENTRIES].found) begin
          dec_kind   = bpbf_pkg::CM_UNLOCK;
          dec_status = bpbf_pkg::STS_UNLOCKED;
          dec_slot   = c_found_slot[TABLE_ENTRIES];
        end
      end
      bpbf_pkg::OP_CLEAR: begin
        dec_kind   = bpbf_pkg::CM_CLEAR;
        dec_status = bpbf_pkg::STS_CLEARED;
        dec_lcnt   = c_lcnt[TABLE_ENTRIES];
      end
      bpbf_pkg::OP_NONE: begin
      end
    endcase
  end

  assign cm_kind = fire ? dec_kind : bpbf_pkg::CM_NONE;
  assign cm_slot = dec_slot;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpbf_pkg::ST_IDLE: begin
        if (accept) state_nxt = bpbf_pkg::ST_SCAN;
      end
      bpbf_pkg::ST_SCAN: begin
        if (scan_v[TABLE_ENTRIES]) begin
          state_nxt = out_free ? bpbf_pkg::ST_IDLE : bpbf_pkg::ST_HOLD;
        end
      end
      bpbf_pkg::ST_HOLD: begin
        if (out_free) state_nxt = bpbf_pkg::ST_IDLE;
      end
      default: state_nxt = bpbf_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = (state_r == bpbf_pkg::ST_IDLE);
    fire        = out_free &&
                  (((state_r == bpbf_pkg::ST_SCAN) && scan_v[TABLE_ENTRIES]) ||
                   (state_r == bpbf_pkg::ST_HOLD));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bpbf_pkg::ST_IDLE;
      count_r  <= '0;
      id_ctr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cm_kind == bpbf_pkg::CM_NEW) begin
        count_r  <= count_r + CNT_W'(1);
        id_ctr_r <= new_id;
      end else if (cm_kind == bpbf_pkg::CM_CLEAR) begin
        count_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= dec_status;
      gid_r    <= dec_id;
      gslot_r  <= dec_slot;
      lcnt_r   <= dec_lcnt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = status_r;
  assign out_ch.granted_id         = gid_r;
  assign out_ch.granted_slot       = bpbf_pkg::SLOT_OUT_W'(gslot_r);
  assign out_ch.still_locked_count = bpbf_pkg::LCNT_OUT_W'(lcnt_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(scan_v))
    else $error("more than one item in the cell row");

  a_new_id: assert property (@(posedge clk) disable iff (!rst_n)
    (cm_kind == bpbf_pkg::CM_NEW) |=> (id_ctr_r == $past(id_ctr_r) + ID_W'(1)))
    else $error("id counter did not advance on new entry");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cm_kind == bpbf_pkg::CM_CLEAR) |=> (count_r == '0))
    else $error("clear left entries in the table");

  a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_valid_r && (state_r == bpbf_pkg::ST_IDLE)))
    else $error("result not presented after table update");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned POOL_DEPTH = 16;
  localparam int unsigned HOLD_AT    = 1400;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned DRAIN_WAIT = 40;

  typedef struct packed {
    bpbf_pkg::status_t st;
    logic [31:0]       id;
    logic [3:0]        slot;
    logic [4:0]        cnt;
  } pool_result_t;

  typedef struct packed {
    bpbf_pkg::op_t op;
    logic [31:0]   size;
    logic [31:0]   rid;
    logic [4:0]    reps;
    logic          typed;
    pool_result_t  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  bpbf_in_if  in_ch ();
  bpbf_out_if out_ch ();

  buffer_pool_best_fit_lock dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the buffer table
  logic [31:0]  pool_size  [POOL_DEPTH];
  logic         pool_lock  [POOL_DEPTH];
  logic [31:0]  pool_ident [POOL_DEPTH];
  int unsigned  pool_count;
  logic [31:0]  id_ctr;

  pool_result_t due_replies [$];
  int unsigned  items_taken = 0;
  int unsigned  errors = 0;
  int unsigned  tx_idle_pct = 14;
  int unsigned  rx_idle_pct = 75;
  int unsigned  hold_left = 0;
  bit           hold_done = 1'b0;

  localparam dir_row_t DIR_ROWS [21] = '{
    '{bpbf_pkg::OP_UNLOCK, 32'd0,         32'd0,         5'd1,  1'b1,
      '{bpbf_pkg::STS_NOTFOUND, 32'd0, 4'd0, 5'd0}},
    '{bpbf_pkg::OP_NONE,   32'hffff_ffff, 32'hffff_ffff, 5'd1,  1'b1,
      '{bpbf_pkg::STS_NOTFOUND, 32'd0, 4'd0, 5'd0}},
    '{bpbf_pkg::OP_CLEAR,  32'd0,         32'd0,         5'd1,  1'b1,
      '{bpbf_pkg::STS_CLEARED,  32'd0, 4'd0, 5'd0}},
    '{bpbf_pkg::OP_LOCK,   32'd0,         32'hffff_ffff, 5'd1,  1'b1,
      '{bpbf_pkg::STS_NEW,      32'd1, 4'd0, 5'd0}},
    '{bpbf_pkg::OP_LOCK,   32'hffff_ffff, 32'd0,         5'd1,  1'b1,
      '{bpbf_pkg::STS_NEW,      32'd2, 4'd1, 5'd0}},
    '{bpbf_pkg::OP_UNLOCK, 32'hffff_ffff, 32'd1,         5'd1,  1'b1,
      '{bpbf_pkg::STS_UNLOCKED, 32'd0, 4'd0, 5'd0}},
    '{bpbf_pkg::OP_LOCK,   32'd0,         32'd0,         5'd1,  1'b0, '0},
    '{bpbf_pkg::OP_LOCK,   32'd100,       32'd0,         5'd1,  1'b0, '0},
    '{bpbf_pkg::OP_UNLOCK, 32'd0,         32'd3,         5'd1,  1'b0, '0},
    '{bpbf_pkg::OP_LOCK,   32'd200,       32'd0,         5'd1,  1'b0, '0},
    '{bpbf_pkg::OP_LOCK,   32'd1,         32'd0,         5'd13, 1'b0, '0},
    '{bpbf_pkg::OP_LOCK,   32'd1,         32'd0,         5'd1,  1'b1,
      '{bpbf_pkg::STS_FULL,     32'd0, 4'd0, 5'd0}},
    '{bpbf_pkg::OP_UNLOCK, 32'd0,         32'd5,         5'd1,  1'b0, '0},
    '{bpbf_pkg::OP_UNLOCK, 32'd0,         32'd4,         5'd1,  1'b0, '0},
    '{bpbf_pkg::OP_LOCK,   32'd1,         32'd0,         5'd1,  1'b0, '0},
    '{bpbf_pkg::OP_UNLOCK, 32'd0,         32'hffff_ffff, 5'd1,  1'b1,
      '{bpbf_pkg::STS_NOTFOUND, 32'd0, 4'd0, 5'd0}},
    '{bpbf_pkg::OP_UNLOCK, 32'd0,         32'd4,         5'd2,  1'b0, '0},
    '{bpbf_pkg::OP_CLEAR,  32'hffff_ffff, 32'hffff_ffff, 5'd1,  1'b0, '0},
    '{bpbf_pkg::OP_LOCK,   32'd7,         32'd0,         5'd1,  1'b0, '0},
    '{bpbf_pkg::OP_UNLOCK, 32'd0,         32'd17,        5'd1,  1'b0, '0},
    '{bpbf_pkg::OP_LOCK,   32'hffff_ffff, 32'd0,         5'd1,  1'b0, '0}
  };

  function automatic void pool_reset();
    int i;
    for (i = 0; i < POOL_DEPTH; i++) begin
      pool_lock[i] = 1'b0;
    end
    pool_count = 0;
    id_ctr = '0;
  endfunction

  function automatic pool_result_t pool_serve(input bpbf_pkg::op_t op,
                                              input logic [31:0] sz,
                                              input logic [31:0] rid);
    pool_result_t r;
    bit           fit_ok, grow_ok;
    int unsigned  fit_slot, grow_slot, i, n;
    logic [31:0]  fit_sz, grow_sz;
    r = '0;
    fit_ok = 1'b0;
    grow_ok = 1'b0;
    fit_slot = 0;
    grow_slot = 0;
    fit_sz = '0;
    grow_sz = '0;
    n = 0;
    case (op)
      bpbf_pkg::OP_LOCK: begin
        for (i = 0; i < pool_count; i++) begin
          if (!pool_lock[i]) begin
            if (pool_size[i] >= sz && (!fit_ok || pool_size[i] < fit_sz)) begin
              fit_ok = 1'b1;
              fit_sz = pool_size[i];
              fit_slot = i;
            end
            if (pool_size[i] != 0 && pool_size[i] < sz &&
                (!grow_ok || pool_size[i] > grow_sz)) begin
              grow_ok = 1'b1;
              grow_sz = pool_size[i];
              grow_slot = i;
            end
          end
        end
        if (fit_ok) begin
          pool_lock[fit_slot] = 1'b1;
          r.st = bpbf_pkg::STS_REUSED;
          r.id = pool_ident[fit_slot];
          r.slot = fit_slot[3:0];
        end else if (grow_ok) begin
          pool_size[grow_slot] = sz;
          pool_lock[grow_slot] = 1'b1;
          r.st = bpbf_pkg::STS_GROWN;
          r.id = pool_ident[grow_slot];
          r.slot = grow_slot[3:0];
        end else if (pool_count < POOL_DEPTH) begin
          id_ctr = id_ctr + 32'd1;
          pool_size[pool_count] = sz;
          pool_lock[pool_count] = 1'b1;
          pool_ident[pool_count] = id_ctr;
          r.st = bpbf_pkg::STS_NEW;
          r.id = id_ctr;
          r.slot = pool_count[3:0];
          pool_count++;
        end else begin
          r.st = bpbf_pkg::STS_FULL;
        end
      end
      bpbf_pkg::OP_UNLOCK: begin
        r.st = bpbf_pkg::STS_NOTFOUND;
        for (i = 0; i < pool_count; i++) begin
          if (r.st == bpbf_pkg::STS_NOTFOUND && pool_ident[i] == rid) begin
            pool_lock[i] = 1'b0;
            r.st = bpbf_pkg::STS_UNLOCKED;
            r.slot = i[3:0];
          end
        end
      end
      bpbf_pkg::OP_CLEAR: begin
        for (i = 0; i < pool_count; i++) begin
          if (pool_lock[i]) n++;
        end
        for (i = 0; i < POOL_DEPTH; i++) begin
          pool_lock[i] = 1'b0;
        end
        pool_count = 0;
        r.st = bpbf_pkg::STS_CLEARED;
        r.cnt = n[4:0];
      end
      default: begin
        r.st = bpbf_pkg::STS_NOTFOUND;
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  task automatic send_item(input bpbf_pkg::op_t op, input logic [31:0] sz,
                           input logic [31:0] rid, input bit typed,
                           input pool_result_t want);
    bit           took;
    pool_result_t calc;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.request_size <= sz;
    in_ch.release_id   <= rid;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end
    items_taken++;
    calc = pool_serve(op, sz, rid);
    due_replies.insert(due_replies.size(), typed ? want : calc);
  endtask

  task automatic random_items(input int unsigned n);
    bpbf_pkg::op_t op;
    logic [31:0]   sz, rid;
    int unsigned   pick, k;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      sz = $urandom();
      rid = $urandom();
      if (pick < 52 || pick >= 96) begin
        op = bpbf_pkg::OP_LOCK;
        pick = (pick >= 96) ? 99 : $urandom_range(99);
        if (pick < 10) sz = '0;
        else if (pick < 65) sz = $urandom_range(64, 1);
        else if (pick < 85) sz = $urandom_range(4096, 65);
      end else if (pick < 88) begin
        op = bpbf_pkg::OP_UNLOCK;
        pick = $urandom_range(99);
        if (pick < 70 && pool_count != 0) rid = pool_ident[$urandom_range(pool_count - 1)];
        else if (pick < 80) rid = id_ctr + $urandom_range(3);
        else if (pick < 90) rid = '0;
      end else if (pick < 93) begin
        op = bpbf_pkg::OP_CLEAR;
      end else begin
        op = bpbf_pkg::OP_NONE;
      end
      send_item(op, sz, rid, 1'b0, '0);
    end
  endtask

  // receiver side, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_taken >= HOLD_AT) begin
      out_ch.ready <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin : reply_monitor
    pool_result_t got, want;
    bit           fire;
    forever begin
      @(negedge clk);
      fire = (rst_n === 1'b1) && (out_ch.valid === 1'b1) && (out_ch.ready === 1'b1);
      got.st   = bpbf_pkg::status_t'(out_ch.status);
      got.id   = out_ch.granted_id;
      got.slot = out_ch.granted_slot;
      got.cnt  = out_ch.still_locked_count;
      @(posedge clk);
      if (fire) begin
        if (due_replies.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual status %0d", $time, got.st);
          errors++;
        end else begin
          want = due_replies.pop_front();
          check_field("status", 32'(want.st), 32'(got.st));
          check_field("granted_id", want.id, got.id);
          check_field("granted_slot", 32'(want.slot), 32'(got.slot));
          check_field("still_locked_count", 32'(want.cnt), 32'(got.cnt));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned ri, rep;
    dir_row_t    row;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= bpbf_pkg::OP_NONE;
    in_ch.request_size <= '0;
    in_ch.release_id   <= '0;
    pool_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (ri = 0; ri < $size(DIR_ROWS); ri++) begin
      row = DIR_ROWS[ri];
      for (rep = 0; rep < row.reps; rep++) begin
        send_item(row.op, row.size, row.rid, row.typed, row.want);
      end
    end

    random_items(600);
    tx_idle_pct = 75;
    rx_idle_pct = 14;
    random_items(600);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_items(550);
    in_ch.valid <= 1'b0;

    while (due_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/bpbf_pkg.sv
src/bpbf_in_if.sv
src/bpbf_out_if.sv
src/bpbf_cell.sv
src/buffer_pool_best_fit_lock.sv
sim/tb_top.sv
